>>> rtl/core/sulsc_pkg.sv
// Shared types and constants of the stereo upmix with soft-clipped LFE.
// Holds the transfer payload structs, register map codes and Q1.31 coefficients.
// No dependencies.
package sulsc_pkg;

    // Field and port widths
    localparam int FIELD_BITS          = 32;
    localparam int SAMPLE_BITS_DEFAULT = 32;
    localparam int DATA_BITS           = 32;
    localparam int ADDR_BITS           = 4;
    localparam int NSTAGE              = 8;

    // Q1.31 coefficients, shifted down for narrower samples
    localparam logic [31:0] Q31_C794       = 32'd1705806895;
    localparam logic [31:0] Q31_C12        = 32'd178956963;
    localparam logic [31:0] Q31_C75        = 32'd1610612736;
    localparam logic [31:0] Q31_KNEE_RESET = 32'd715827883;
    localparam logic [31:0] Q31_CLIP_RESET = 32'd1431655765;

    // Register map, word index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_GAIN = 2'd0,
        REG_MODE = 2'd1,
        REG_KNEE = 2'd2,
        REG_CLIP = 2'd3
    } reg_idx_t;

    // Output mode codes
    localparam logic [1:0] MODE_220 = 2'd0;
    localparam logic [1:0] MODE_221 = 2'd1;
    localparam logic [1:0] MODE_320 = 2'd2;
    localparam logic [1:0] MODE_321 = 2'd3;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] left_sample;
        logic signed [FIELD_BITS-1:0] right_sample;
    } sample_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] left_out;
        logic signed [FIELD_BITS-1:0] right_out;
        logic signed [FIELD_BITS-1:0] left_surround;
        logic signed [FIELD_BITS-1:0] right_surround;
        logic signed [FIELD_BITS-1:0] center_out;
        logic                         center_valid;
        logic signed [FIELD_BITS-1:0] lfe_out;
        logic                         lfe_valid;
    } frame_t;

endpackage

>>> rtl/core/stereo_upmix_lfe_soft_clip.sv
// Stereo to six-channel upmix with gain, center mix and soft-clipped LFE.
// Eight-stage pipeline plus APB register file.
// Depends on sulsc_pkg.
//
// Usage:
//   sample channel (valid/ready) carries one stereo pair per transfer; frame
//   channel (valid/ready) returns one six-channel frame per pair, in order.
//   Configuration goes through the APB port: gain at 0x0, output_mode at 0x4,
//   knee_threshold at 0x8, clip_threshold at 0xC. Write only while idle.
// Throughput: one pair per cycle while frame_ready holds; the LFE path (square,
//   coefficient multiply, two saturating adds, final select) sets the depth, with
//   at most one multiply in series per stage on the way.
// Stall: each stage holds its item while the next one is full and stalled; an empty stage
//   refills even when the frame output is stalled, so bubbles are squeezed
//   out and sample_ready drops only when all eight stages hold items.
// Reset: rst_n clears all stage valid bits and loads the register defaults
//   (gain at full scale, mode 2/2/0, knee 1/3, clip 2/3).
module stereo_upmix_lfe_soft_clip #(
    parameter int SAMPLE_BITS = sulsc_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample channel
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  sulsc_pkg::sample_t                sample,
    // frame channel
    output logic                              frame_valid,
    input  logic                              frame_ready,
    output sulsc_pkg::frame_t                 frame,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sulsc_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [sulsc_pkg::DATA_BITS-1:0]   pwdata,
    output logic [sulsc_pkg::DATA_BITS-1:0]   prdata,
    output logic                              pready
);

    localparam int W     = SAMPLE_BITS;
    localparam int F     = SAMPLE_BITS - 1;
    localparam int SHIFT = 32 - SAMPLE_BITS;
    localparam int NS    = sulsc_pkg::NSTAGE;

    localparam logic signed [W-1:0] MAXV     = W'((64'd1 << F) - 64'd1);
    localparam logic signed [W-1:0] MINV     = ~MAXV;
    localparam logic signed [W-1:0] HALF     = W'(64'd1 << (F - 1));
    localparam logic signed [W-1:0] NEG_HALF = -HALF;
    localparam logic signed [W-1:0] C794     = W'(sulsc_pkg::Q31_C794 >> SHIFT);
    localparam logic signed [W-1:0] C12      = W'(sulsc_pkg::Q31_C12 >> SHIFT);
    localparam logic signed [W-1:0] C75      = W'(sulsc_pkg::Q31_C75 >> SHIFT);

    localparam logic [31:0] GAIN_RESET = 32'((64'd1 << F) - 64'd1);
    localparam logic [30:0] KNEE_RESET = 31'(sulsc_pkg::Q31_KNEE_RESET >> SHIFT);
    localparam logic [30:0] CLIP_RESET = 31'(sulsc_pkg::Q31_CLIP_RESET >> SHIFT);

    typedef enum logic [1:0] {
        RGN_LINEAR,
        RGN_KNEE,
        RGN_CLIP
    } rgn_t;

    // values that ride along once the gained samples are known
    typedef struct packed {
        logic signed [W-1:0] l;
        logic signed [W-1:0] r;
        logic signed [W-1:0] ls;
        logic signed [W-1:0] rs;
        logic signed [W-1:0] center;
        logic signed [W-1:0] x;
        logic                has_c;
        logic                has_lfe;
    } carry_t;

    // saturate a W+1 bit value to W bits
    function automatic logic signed [W-1:0] sat_w(input logic signed [W:0] v);
        if (v[W] != v[W-1]) begin
            return v[W] ? MINV : MAXV;
        end
        return v[W-1:0];
    endfunction

    // product back to Q1.F: floor shift, then saturate
    function automatic logic signed [W-1:0] scale_sat(input logic signed [2*W-1:0] p);
        logic signed [2*W-1:0] s;
        s = p >>> F;
        return sat_w(s[W:0]);
    endfunction

    function automatic logic signed [W-1:0] add_sat(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b,
                                                    input logic            sub);
        logic signed [W:0] ea;
        logic signed [W:0] eb;
        ea = {a[W-1], a};
        eb = {b[W-1], b};
        return sat_w(sub ? (ea - eb) : (ea + eb));
    endfunction

    function automatic logic signed [W-1:0] neg_sat(input logic signed [W-1:0] a);
        logic signed [W:0] e;
        e = {a[W-1], a};
        e = -e;
        return sat_w(e);
    endfunction

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [31:0]         gain_reg;
    logic [1:0]          mode_reg;
    logic [30:0]         knee_reg;
    logic [30:0]         clip_reg;
    sulsc_pkg::reg_idx_t reg_idx;
    logic                reg_write;

    assign pready    = 1'b1;
    assign reg_idx   = sulsc_pkg::reg_idx_t'(paddr[3:2]);
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            mode_reg <= sulsc_pkg::MODE_220;
            knee_reg <= KNEE_RESET;
            clip_reg <= CLIP_RESET;
        end
        else if (reg_write)
        begin
            unique case (reg_idx)
                sulsc_pkg::REG_GAIN: gain_reg <= pwdata;
                sulsc_pkg::REG_MODE: mode_reg <= pwdata[1:0];
                sulsc_pkg::REG_KNEE: knee_reg <= pwdata[30:0];
                sulsc_pkg::REG_CLIP: clip_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            sulsc_pkg::REG_GAIN: prdata = gain_reg;
            sulsc_pkg::REG_MODE: prdata = {30'd0, mode_reg};
            sulsc_pkg::REG_KNEE: prdata = {1'b0, knee_reg};
            sulsc_pkg::REG_CLIP: prdata = {1'b0, clip_reg};
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage takes new data when empty or draining
    // ------------------------------------------------------------------
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] stage_en;
    logic [NS-1:0] load;

    always_comb
    begin
        stage_en[NS-1] = !valid_reg[NS-1] || frame_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
        load[0] = stage_en[0] && sample_valid;
        for (int i = 1; i < NS; i++)
        begin
            load[i] = stage_en[i] && valid_reg[i-1];
        end
    end

    assign sample_ready = stage_en[0];
    assign frame_valid  = valid_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= sample_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (stage_en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: gain products
    // ------------------------------------------------------------------
    logic signed [W-1:0]   left_w;
    logic signed [W-1:0]   right_w;
    logic signed [W-1:0]   gain_w;
    logic signed [2*W-1:0] s1_pl_next;
    logic signed [2*W-1:0] s1_pr_next;
    logic signed [2*W-1:0] s1_pl_reg;
    logic signed [2*W-1:0] s1_pr_reg;
    logic                  s1_c_reg;
    logic                  s1_lfe_reg;

    assign left_w     = sample.left_sample[W-1:0];
    assign right_w    = sample.right_sample[W-1:0];
    assign gain_w     = gain_reg[W-1:0];
    assign s1_pl_next = left_w * gain_w;
    assign s1_pr_next = right_w * gain_w;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_pl_reg  <= s1_pl_next;
            s1_pr_reg  <= s1_pr_next;
            s1_c_reg   <= (mode_reg == sulsc_pkg::MODE_320) ||
                          (mode_reg == sulsc_pkg::MODE_321);
            s1_lfe_reg <= (mode_reg == sulsc_pkg::MODE_221) ||
                          (mode_reg == sulsc_pkg::MODE_321);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: gained samples back to Q1.F
    // ------------------------------------------------------------------
    logic signed [W-1:0] s2_l_reg;
    logic signed [W-1:0] s2_r_reg;
    logic                s2_c_reg;
    logic                s2_lfe_reg;

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s2_l_reg   <= scale_sat(s1_pl_reg);
            s2_r_reg   <= scale_sat(s1_pr_reg);
            s2_c_reg   <= s1_c_reg;
            s2_lfe_reg <= s1_lfe_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: 0.794 scaling products
    // ------------------------------------------------------------------
    logic signed [2*W-1:0] s3_plg_next;
    logic signed [2*W-1:0] s3_prg_next;
    logic signed [2*W-1:0] s3_plg_reg;
    logic signed [2*W-1:0] s3_prg_reg;
    logic signed [W-1:0]   s3_l_reg;
    logic signed [W-1:0]   s3_r_reg;
    logic                  s3_c_reg;
    logic                  s3_lfe_reg;

    assign s3_plg_next = s2_l_reg * C794;
    assign s3_prg_next = s2_r_reg * C794;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s3_plg_reg <= s3_plg_next;
            s3_prg_reg <= s3_prg_next;
            s3_l_reg   <= s2_l_reg;
            s3_r_reg   <= s2_r_reg;
            s3_c_reg   <= s2_c_reg;
            s3_lfe_reg <= s2_lfe_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: center mix, surrounds, LFE input
    // ------------------------------------------------------------------
    logic signed [W-1:0] s4_lg;
    logic signed [W-1:0] s4_rg;
    carry_t              s4_next;
    carry_t              s4_reg;

    always_comb
    begin
        s4_lg           = scale_sat(s3_plg_reg);
        s4_rg           = scale_sat(s3_prg_reg);
        s4_next.l       = s3_l_reg;
        s4_next.r       = s3_r_reg;
        s4_next.ls      = neg_sat(s3_l_reg);
        s4_next.rs      = neg_sat(s3_r_reg);
        s4_next.center  = add_sat(s4_lg, s4_rg, 1'b0);
        s4_next.x       = s4_rg;
        s4_next.has_c   = s3_c_reg;
        s4_next.has_lfe = s3_lfe_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            s4_reg <= s4_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: soft clip region, x squared, offset by 1/12
    // ------------------------------------------------------------------
    logic signed [W:0]     x_ext;
    logic signed [W:0]     knee_ext;
    logic signed [W:0]     clip_ext;
    logic                  above_knee;
    logic                  below_knee;
    rgn_t                  s5_rgn_next;
    logic signed [2*W-1:0] s5_pxx_next;
    logic signed [2*W-1:0] s5_pxx_reg;
    logic signed [W-1:0]   s5_v1_reg;
    rgn_t                  s5_rgn_reg;
    logic                  s5_neg_reg;
    carry_t                s5_reg;

    always_comb
    begin
        x_ext      = {s4_reg.x[W-1], s4_reg.x};
        knee_ext   = {2'b00, knee_reg[F-1:0]};
        clip_ext   = {2'b00, clip_reg[F-1:0]};
        above_knee = x_ext > knee_ext;
        below_knee = x_ext < -knee_ext;
        priority if (above_knee)
        begin
            s5_rgn_next = (x_ext > clip_ext) ? RGN_CLIP : RGN_KNEE;
        end
        else if (below_knee)
        begin
            s5_rgn_next = (x_ext < -clip_ext) ? RGN_CLIP : RGN_KNEE;
        end
        else
        begin
            s5_rgn_next = RGN_LINEAR;
        end
    end

    assign s5_pxx_next = s4_reg.x * s4_reg.x;

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            s5_pxx_reg <= s5_pxx_next;
            // positive knee subtracts, negative knee adds
            s5_v1_reg  <= add_sat(s4_reg.x, C12, above_knee);
            s5_rgn_reg <= s5_rgn_next;
            s5_neg_reg <= !above_knee;
            s5_reg     <= s4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: 0.75 * x^2 product
    // ------------------------------------------------------------------
    logic signed [2*W-1:0] s6_pt_next;
    logic signed [2*W-1:0] s6_pt_reg;
    logic signed [W-1:0]   s6_v1_reg;
    rgn_t                  s6_rgn_reg;
    logic                  s6_neg_reg;
    carry_t                s6_reg;

    assign s6_pt_next = C75 * scale_sat(s5_pxx_reg);

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            s6_pt_reg  <= s6_pt_next;
            s6_v1_reg  <= s5_v1_reg;
            s6_rgn_reg <= s5_rgn_reg;
            s6_neg_reg <= s5_neg_reg;
            s6_reg     <= s5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: knee polynomial before doubling
    // ------------------------------------------------------------------
    logic signed [W-1:0] s7_v2_reg;
    rgn_t                s7_rgn_reg;
    logic                s7_neg_reg;
    carry_t              s7_reg;

    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            s7_v2_reg  <= add_sat(s6_v1_reg, scale_sat(s6_pt_reg), !s6_neg_reg);
            s7_rgn_reg <= s6_rgn_reg;
            s7_neg_reg <= s6_neg_reg;
            s7_reg     <= s6_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: LFE select and output frame register
    // ------------------------------------------------------------------
    logic signed [W-1:0] lfe_w;
    sulsc_pkg::frame_t   frame_next;
    sulsc_pkg::frame_t   frame_reg;

    always_comb
    begin
        unique case (s7_rgn_reg)
            RGN_CLIP:   lfe_w = s7_neg_reg ? NEG_HALF : HALF;
            RGN_KNEE:   lfe_w = sat_w({s7_v2_reg, 1'b0});
            RGN_LINEAR: lfe_w = s7_reg.x;
            default:    lfe_w = s7_reg.x;
        endcase

        frame_next.left_out       = 32'(s7_reg.l);
        frame_next.right_out      = 32'(s7_reg.r);
        frame_next.left_surround  = 32'(s7_reg.ls);
        frame_next.right_surround = 32'(s7_reg.rs);
        frame_next.center_out     = s7_reg.has_c ? 32'(s7_reg.center) : '0;
        frame_next.center_valid   = s7_reg.has_c;
        frame_next.lfe_out        = s7_reg.has_lfe ? 32'(lfe_w) : '0;
        frame_next.lfe_valid      = s7_reg.has_lfe;
    end

    always_ff @(posedge clk)
    begin
        if (load[7])
        begin
            frame_reg <= frame_next;
        end
    end

    assign frame = frame_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // sample_ready drops only when every stage is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> (&valid_reg))
        else $error("sample_ready low with an empty pipeline stage");

    // an accepted pair always lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> valid_reg[0])
        else $error("accepted sample pair lost at pipeline entry");

    // an absent LFE channel reads as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && !frame.lfe_valid) |-> (frame.lfe_out == '0))
        else $error("lfe_out nonzero while LFE is absent");

    // surround is the saturated negation of the front channel
    assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && (frame.left_out != 32'(MINV)))
            |-> (frame.left_surround == -frame.left_out))
        else $error("left_surround is not the negated left_out");

endmodule
